@@ src/tfcs_pkg.sv @@
package tfcs_pkg;

    localparam int FRAME_W = 22;
    localparam int NOW_W   = 63;
    localparam int DLY_W   = 24;
    localparam int CFG_DW  = 24;
    localparam int CFG_AW  = 2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame_number;
        logic [NOW_W-1:0]   now_ns;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] event_frame;
        logic               timer_armed;
        logic [DLY_W-1:0]   timer_delay_us;
        logic               synced;
        logic [2:0]         status;
        logic               last;
    } t_rsp;

    localparam logic [1:0] OP_CLOCK = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [2:0] ST_NORMAL     = 3'd0;
    localparam logic [2:0] ST_INIT_SYNC  = 3'd1;
    localparam logic [2:0] ST_FRAME_SKEW = 3'd2;
    localparam logic [2:0] ST_TIME_SKEW  = 3'd3;
    localparam logic [2:0] ST_LOSS       = 3'd4;
    localparam logic [2:0] ST_AHEAD      = 3'd5;
    localparam logic [2:0] ST_RESET      = 3'd6;
    localparam logic [2:0] ST_IGNORED    = 3'd7;

    localparam logic [CFG_AW-1:0] REG_PERIOD_NS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_PERIOD_US = 2'd1;
    localparam logic [CFG_AW-1:0] REG_LOSS      = 2'd2;

    localparam logic [23:0] RST_PERIOD_NS = 24'd4615384;
    localparam logic [15:0] RST_PERIOD_US = 16'd4615;
    localparam logic [15:0] RST_LOSS      = 16'd400;

endpackage

@@ src/tfcs_cdiv.sv @@
module tfcs_cdiv #(
    parameter int W   = 22,
    parameter int DIV = 2715648
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [W-1:0]             i_dividend,
    output logic                     o_done,
    output logic [$clog2(DIV)-1:0]   o_rem
);
    localparam int RW = $clog2(DIV);
    localparam int QB = (W + 1 - RW > 0) ? W + 1 - RW : 1;
    localparam int KW = (QB > 1) ? $clog2(QB) : 1;
    localparam logic [W:0] DIVC = (W + 1)'(DIV);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_k;
    logic [W:0]    r_val;
    logic [W:0]    w_sub;
    logic          w_ge;

    // one compare and subtract of a shifted divisor per cycle
    assign w_sub = DIVC << r_k;
    assign w_ge  = r_val >= w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= KW'(QB - 1);
                r_val  <= {1'b0, i_dividend};
            end else if (r_busy) begin
                if (w_ge) r_val <= r_val - w_sub;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_val[RW-1:0];
endmodule

@@ src/tfcs_front.sv @@
module tfcs_front #(
    parameter int HYPERFRAME = 2715648
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfcs_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_q_push,
    output tfcs_pkg::t_req o_q_data,
    input  logic          i_q_full
);
    import tfcs_pkg::*;

    localparam int RW = $clog2(HYPERFRAME);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate r_state;
    t_req    r_item;
    logic    w_start;
    logic    w_done;
    logic [RW-1:0] w_rem;

    assign w_start = (r_state == F_IDLE) && i_push;

    tfcs_cdiv #(.W(FRAME_W), .DIV(HYPERFRAME)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (i_req.frame_number),
        .o_done     (w_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_item  <= i_req;
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (w_done) begin
                        r_item.frame_number <= FRAME_W'(w_rem);
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_full   = r_state != F_IDLE;
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = r_item;
endmodule

@@ src/tfcs_queue.sv @@
module tfcs_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfcs_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output tfcs_pkg::t_req o_data,
    output logic          o_empty
);
    import tfcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_req          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
endmodule

@@ src/tfcs_back.sv @@
module tfcs_back #(
    parameter int MAX_SKEW   = 50,
    parameter int HYPERFRAME = 2715648
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tfcs_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [tfcs_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                            i_q_empty,
    input  tfcs_pkg::t_req                  i_q_data,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  logic                            i_pop,
    output tfcs_pkg::t_rsp                  o_rsp
);
    import tfcs_pkg::*;

    localparam int BW = $clog2(MAX_SKEW + 1);
    localparam logic [22:0] HF    = 23'(HYPERFRAME);
    localparam logic [22:0] HHALF = 23'(HYPERFRAME / 2);
    localparam logic [22:0] MSK   = 23'(MAX_SKEW);
    localparam logic [FRAME_W-1:0] PF_LAST = FRAME_W'(HYPERFRAME - 1);
    // x / 1000 == (x * RECIP_1000) >> 38 for any 32-bit x
    localparam logic [28:0] RECIP_1000 = 29'd274877907;

    typedef enum logic [3:0] {
        B_IDLE, B_CLASS, B_FRAME, B_RESYNC, B_AHEAD, B_AHEAD2, B_CATCH,
        B_THR, B_SKEW, B_DIVW, B_TICK, B_DONE
    } t_bstate;

    t_bstate r_state;
    logic [23:0] r_cfg_ns;
    logic [15:0] r_cfg_us;
    logic [15:0] r_cfg_loss;

    logic               r_sync;
    logic [FRAME_W-1:0] r_pf;
    logic [15:0]        r_lost;
    logic [63:0]        r_ref;
    logic               r_armed;

    logic [1:0]         r_op;
    logic [FRAME_W-1:0] r_fn;
    logic [NOW_W-1:0]   r_now;
    logic [DLY_W-1:0]   r_delay;
    logic [2:0]         r_status;
    logic [22:0]        r_diff;
    logic [BW-1:0]      r_back;
    logic [BW+23:0]     r_prodns;
    logic               r_dneg;
    logic [63:0]        r_d;
    logic [22:0]        r_pms;
    logic [31:0]        r_thr;
    logic [60:0]        r_prod;
    logic signed [23:0] r_el;

    logic               r_out_v;
    t_rsp               r_out;

    logic [15:0]        w_p;
    logic               w_out_free;
    logic               w_load;
    logic [22:0]        w_sum;
    logic [22:0]        w_neg;
    logic [FRAME_W-1:0] w_pf_inc;
    logic [64:0]        w_dsub;
    logic               w_over;
    logic signed [23:0] w_ps;
    logic signed [23:0] w_half;
    t_rsp               w_ev;
    t_rsp               w_rs;

    assign w_p        = (r_cfg_us == '0) ? 16'd1 : r_cfg_us;
    assign w_out_free = !r_out_v || i_pop;
    assign w_sum      = 23'(r_fn) + HF - 23'(r_pf);
    assign w_neg      = HF - r_diff;
    assign w_pf_inc   = (r_pf == PF_LAST) ? '0 : r_pf + 1'b1;
    assign w_dsub     = {2'b00, r_now} - {1'b0, r_ref};
    assign w_over     = r_dneg || (|r_d[63:32]) || (r_d[31:0] >= r_thr);
    assign w_ps       = $signed({8'b0, w_p});
    assign w_half     = $signed({9'b0, w_p[15:1]});
    assign w_load     = w_out_free && ((r_state == B_RESYNC) || (r_state == B_DONE) ||
                        (r_state == B_CATCH && r_pf != r_fn) ||
                        (r_state == B_TICK && r_el > w_half));

    always_comb begin
        w_ev                = '0;
        w_ev.kind           = 1'b0;
        w_ev.event_frame    = w_pf_inc;
        w_ev.synced         = 1'b1;
        w_ev.status         = ST_NORMAL;
        w_rs                = w_ev;
        w_rs.event_frame    = r_fn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_cfg_ns   <= RST_PERIOD_NS;
            r_cfg_us   <= RST_PERIOD_US;
            r_cfg_loss <= RST_LOSS;
            r_sync     <= 1'b0;
            r_pf       <= '0;
            r_lost     <= '0;
            r_ref      <= '0;
            r_armed    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_PERIOD_NS: r_cfg_ns   <= i_cfg_wdata;
                    REG_PERIOD_US: r_cfg_us   <= i_cfg_wdata[15:0];
                    REG_LOSS:      r_cfg_loss <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (w_load) r_out_v <= 1'b1;
            else if (i_pop) r_out_v <= 1'b0;

            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_op     <= i_q_data.operation;
                        r_fn     <= i_q_data.frame_number;
                        r_now    <= i_q_data.now_ns;
                        r_delay  <= '0;
                        r_status <= ST_IGNORED;
                        r_state  <= B_CLASS;
                    end
                end
                B_CLASS: begin
                    unique case (r_op)
                        OP_CLOCK: begin
                            r_lost <= '0;
                            if (!r_sync) begin
                                r_status <= ST_INIT_SYNC;
                                r_state  <= B_RESYNC;
                            end else begin
                                r_diff  <= (w_sum >= HF) ? w_sum - HF : w_sum;
                                r_state <= B_FRAME;
                            end
                        end
                        OP_TIMER: begin
                            if (!r_armed) begin
                                r_state <= B_DONE;
                            end else begin
                                if (r_lost != 16'hFFFF) r_lost <= r_lost + 1'b1;
                                if (r_lost == r_cfg_loss) begin
                                    r_sync   <= 1'b0;
                                    r_armed  <= 1'b0;
                                    r_status <= ST_LOSS;
                                    r_state  <= B_DONE;
                                end else begin
                                    r_dneg  <= w_dsub[64];
                                    r_d     <= w_dsub[63:0];
                                    r_pms   <= 23'(w_p * 23'(MAX_SKEW));
                                    r_state <= B_THR;
                                end
                            end
                        end
                        OP_RESET: begin
                            r_sync   <= 1'b0;
                            r_armed  <= 1'b0;
                            r_pf     <= '0;
                            r_lost   <= '0;
                            r_status <= ST_RESET;
                            r_state  <= B_DONE;
                        end
                        default: r_state <= B_DONE;
                    endcase
                end
                B_FRAME: begin
                    if ((r_diff < HHALF && r_diff > MSK) ||
                        (r_diff >= HHALF && w_neg > MSK)) begin
                        r_status <= ST_FRAME_SKEW;
                        r_state  <= B_RESYNC;
                    end else if (r_diff >= HHALF) begin
                        r_back  <= BW'(w_neg);
                        r_state <= B_AHEAD;
                    end else begin
                        r_ref    <= {1'b0, r_now};
                        r_armed  <= 1'b1;
                        r_delay  <= DLY_W'(w_p);
                        r_status <= ST_NORMAL;
                        r_state  <= B_CATCH;
                    end
                end
                B_RESYNC: begin
                    if (w_out_free) begin
                        r_out             <= w_rs;
                        r_sync            <= 1'b1;
                        r_pf              <= r_fn;
                        r_ref             <= {1'b0, r_now};
                        r_armed           <= 1'b1;
                        r_delay           <= DLY_W'(w_p);
                        r_state           <= B_DONE;
                    end
                end
                B_AHEAD: begin
                    r_prodns <= r_back * r_cfg_ns;
                    r_delay  <= DLY_W'(w_p) * DLY_W'(r_back + 1'b1);
                    r_state  <= B_AHEAD2;
                end
                B_AHEAD2: begin
                    r_ref    <= {1'b0, r_now} + 64'(r_prodns);
                    r_armed  <= 1'b1;
                    r_status <= ST_AHEAD;
                    r_state  <= B_DONE;
                end
                B_CATCH: begin
                    if (r_pf == r_fn) begin
                        r_state <= B_DONE;
                    end else if (w_out_free) begin
                        r_out   <= w_ev;
                        r_pf    <= w_pf_inc;
                    end
                end
                B_THR: begin
                    r_thr   <= 32'((42'(r_pms) + 42'd1) * 42'd1000);
                    r_state <= B_SKEW;
                end
                B_SKEW: begin
                    if (w_over) begin
                        r_sync   <= 1'b0;
                        r_armed  <= 1'b0;
                        r_status <= ST_TIME_SKEW;
                        r_state  <= B_DONE;
                    end else begin
                        r_prod  <= r_d[31:0] * RECIP_1000;
                        r_state <= B_DIVW;
                    end
                end
                B_DIVW: begin
                    r_el    <= $signed({1'b0, r_prod[60:38]});
                    r_state <= B_TICK;
                end
                B_TICK: begin
                    if (r_el > w_half) begin
                        if (w_out_free) begin
                            r_out   <= w_ev;
                            r_pf    <= w_pf_inc;
                            r_ref   <= r_ref + 64'(r_cfg_ns);
                            r_el    <= r_el - w_ps;
                        end
                    end else begin
                        r_delay  <= DLY_W'(w_ps - r_el);
                        r_status <= ST_NORMAL;
                        r_state  <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (w_out_free) begin
                        r_out.kind           <= 1'b1;
                        r_out.event_frame    <= r_pf;
                        r_out.timer_armed    <= r_armed;
                        r_out.timer_delay_us <= r_armed ? r_delay : '0;
                        r_out.synced         <= r_sync;
                        r_out.status         <= r_status;
                        r_out.last           <= 1'b1;
                        r_state              <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty = !r_out_v;
    assign o_rsp   = r_out;
endmodule

@@ src/tdma_frame_clock_sync.sv @@
// TDMA frame clock synchronizer. Requests enter through a push/full port; the
// front end reduces the frame number modulo the hyperframe by compare and
// subtract (one step for the default hyperframe, one more per extra quotient
// bit for a smaller one), so it stays busy after each accepted request until it
// has handed the request through a two-entry queue to the back end, which
// updates the sync state and emits results through a pop/empty output
// register. In the back end a resync, an in-range clock indication, a clock
// running ahead and a timer expiry each pass through their own states, while
// loss, reset and ignored requests go straight to the result; in-range clock
// indications and timer expiries also emit frame events one at a time (the
// divide by 1000 is a reciprocal multiply). Results stall only when the output
// register is not popped. Configuration writes take effect at once and are
// expected only while no request is in flight.
module tdma_frame_clock_sync #(
    parameter int MAX_SKEW   = 50,
    parameter int HYPERFRAME = 2715648
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  tfcs_pkg::t_req              i_req,
    output logic                        o_full,
    output logic                        o_empty,
    input  logic                        i_pop,
    output tfcs_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic [tfcs_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tfcs_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import tfcs_pkg::*;

    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;
    t_req w_q_in;
    t_req w_q_out;

    tfcs_front #(.HYPERFRAME(HYPERFRAME)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_req    (i_req),
        .o_full   (o_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_in),
        .i_q_full (w_q_full)
    );

    tfcs_queue #(.DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    tfcs_back #(.MAX_SKEW(MAX_SKEW), .HYPERFRAME(HYPERFRAME)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (w_q_empty),
        .i_q_data    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_rsp       (o_rsp)
    );
endmodule

@@ src/tfcs_checker.sv @@
module tfcs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_push,
    input logic           o_full,
    input logic           o_empty,
    input logic           i_pop,
    input tfcs_pkg::t_rsp o_rsp
);
    import tfcs_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("queues not clear after reset");

    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !o_full |=> o_full)
        else $error("front end took a request without going busy");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_rsp))
        else $error("waiting result changed");

    a_event_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_rsp.kind |-> o_rsp.synced && !o_rsp.last &&
            !o_rsp.timer_armed && o_rsp.status == ST_NORMAL)
        else $error("malformed frame event");
endmodule

bind tdma_frame_clock_sync tfcs_checker u_tfcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_rsp   (o_rsp)
);
